/* rtl/q2rm_pkg.sv */
// Package: widths, payload structs and pipeline constants of the quaternion to matrix block.
`default_nettype none
package q2rm_pkg;
  localparam int IN_W     = 16;
  localparam int OUT_FRAC = 14;
  localparam int OUT_W    = OUT_FRAC + 2;
  localparam int PROD_W   = 2 * IN_W;
  localparam int NORM_W   = PROD_W + 1;
  localparam int EXP_W    = PROD_W + 3;
  localparam int REM_W    = PROD_W + 2;
  localparam int QUO_W    = OUT_FRAC + 1;
  localparam int DIV_STG  = QUO_W;
  localparam int LATENCY  = DIV_STG + 4;
  localparam int NUM_ENT  = 9;

  typedef struct packed {
    logic signed [IN_W-1:0] qx;
    logic signed [IN_W-1:0] qy;
    logic signed [IN_W-1:0] qz;
    logic signed [IN_W-1:0] qw;
  } quat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
  } matrix_t;
endpackage
`default_nettype wire

/* rtl/quaternion_to_rotation_matrix.sv */
// Top level: fully pipelined quaternion to normalized 3x3 rotation matrix converter.
`default_nettype none
// Channel   Ports                 Direction  Transfer
// input     start, busy, quat     in         start high and busy low at a clock edge
// result    done, matrix          out        one cycle with done high, cannot be held off
//
// Every entry is E/N, where N is the squared norm, so no square root is needed.
// The block takes one quaternion per cycle; busy is always low.
// A result passes through one multiply stage, one sum stage, one sign stage,
// fifteen restoring divide stages (one quotient bit each) and one rounding stage.
// Synchronous reset clears the valid bits of all stages; data registers are not reset.
module quaternion_to_rotation_matrix (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire q2rm_pkg::quat_t  quat,
  output logic                  done,
  output q2rm_pkg::matrix_t     matrix
);
  localparam int PW = q2rm_pkg::PROD_W;
  localparam int NW = q2rm_pkg::NORM_W;
  localparam int EW = q2rm_pkg::EXP_W;
  localparam int AW = q2rm_pkg::REM_W;
  localparam int QW = q2rm_pkg::QUO_W;
  localparam int OW = q2rm_pkg::OUT_W;
  localparam int DS = q2rm_pkg::DIV_STG;
  localparam int NE = q2rm_pkg::NUM_ENT;
  localparam logic [OW-1:0] ONE = OW'(1) << q2rm_pkg::OUT_FRAC;

  // The block never stalls its sender.
  assign busy = 1'b0;

  // Stage 1: the ten products of the components.
  logic v1;
  logic signed [PW-1:0] xx, yy, zz, ww, xy, xz, yz, xw, yw, zw;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start && !busy;
    xx <= quat.qx * quat.qx;
    yy <= quat.qy * quat.qy;
    zz <= quat.qz * quat.qz;
    ww <= quat.qw * quat.qw;
    xy <= quat.qx * quat.qy;
    xz <= quat.qx * quat.qz;
    yz <= quat.qy * quat.qz;
    xw <= quat.qx * quat.qw;
    yw <= quat.qy * quat.qw;
    zw <= quat.qz * quat.qw;
  end

  // Stage 2: squared norm and the nine numerators.
  logic v2;
  logic [NW-1:0] n2;
  logic signed [EW-1:0] e2 [NE];
  logic signed [EW-1:0] nsum;
  always_comb begin
    nsum = EW'(xx) + EW'(yy) + EW'(zz) + EW'(ww);
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    n2    <= nsum[NW-1:0];
    e2[0] <= nsum - 2 * (EW'(yy) + EW'(zz));
    e2[1] <= 2 * (EW'(xy) + EW'(zw));
    e2[2] <= 2 * (EW'(xz) - EW'(yw));
    e2[3] <= 2 * (EW'(xy) - EW'(zw));
    e2[4] <= nsum - 2 * (EW'(xx) + EW'(zz));
    e2[5] <= 2 * (EW'(yz) + EW'(xw));
    e2[6] <= 2 * (EW'(xz) + EW'(yw));
    e2[7] <= 2 * (EW'(yz) - EW'(xw));
    e2[8] <= nsum - 2 * (EW'(xx) + EW'(yy));
  end

  // Stage 3 (divider index 0): magnitude, sign, the full-scale flag and the zero-norm flag.
  logic          dv   [DS+1];
  logic          dz   [DS+1];
  logic [NW-1:0] dn   [DS+1];
  logic [AW-1:0] da   [DS+1][NE];
  logic [QW-1:0] dq   [DS+1][NE];
  logic          dneg [DS+1][NE];
  logic          dsat [DS+1][NE];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else     dv[0] <= v2;
    dz[0] <= (n2 == '0);
    dn[0] <= n2;
  end

  for (genvar j = 0; j < NE; j++) begin : g_abs
    logic signed [EW-1:0] mag;
    assign mag = e2[j][EW-1] ? -e2[j] : e2[j];
    always_ff @(posedge clk) begin
      da[0][j]   <= mag[AW-1:0];
      dq[0][j]   <= '0;
      dneg[0][j] <= e2[j][EW-1];
      dsat[0][j] <= (mag >= EW'(n2));
    end
  end

  // Restoring divide: one quotient bit per stage for all nine entries.
  for (genvar k = 1; k <= DS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv[k] <= 1'b0;
      else     dv[k] <= dv[k-1];
      dz[k] <= dz[k-1];
      dn[k] <= dn[k-1];
    end
    for (genvar j = 0; j < NE; j++) begin : g_lane
      logic [AW-1:0] sh;
      logic          ge;
      assign sh = {da[k-1][j][AW-2:0], 1'b0};
      assign ge = (sh >= AW'(dn[k-1]));
      always_ff @(posedge clk) begin
        da[k][j]   <= ge ? (sh - AW'(dn[k-1])) : sh;
        dq[k][j]   <= {dq[k-1][j][QW-2:0], ge};
        dneg[k][j] <= dneg[k-1][j];
        dsat[k][j] <= dsat[k-1][j];
      end
    end
  end

  // Final stage: round half away from zero, saturate, apply sign; a zero norm gives the identity.
  logic [OW-1:0] res [NE];
  for (genvar j = 0; j < NE; j++) begin : g_rnd
    logic [OW-1:0] rmag;
    logic [OW-1:0] cmag;
    assign rmag = (OW'(dq[DS][j]) + OW'(1)) >> 1;
    assign cmag = (dsat[DS][j] || rmag > ONE) ? ONE : rmag;
    always_comb begin
      if (dz[DS])          res[j] = (j % 4 == 0) ? ONE : '0;
      else if (dneg[DS][j]) res[j] = -cmag;
      else                 res[j] = cmag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv[DS];
    matrix <= {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8]};
  end

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, q2rm_pkg::LATENCY))
    else $error("result without a matching input transfer");

  a_diag_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (matrix.m00 <= $signed(ONE)) && (matrix.m00 >= -$signed(ONE)) &&
             (matrix.m11 <= $signed(ONE)) && (matrix.m11 >= -$signed(ONE)))
    else $error("diagonal entry out of range");

  a_zero_quat: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && (quat == '0), q2rm_pkg::LATENCY)) |->
      (matrix.m00 == $signed(ONE)) && (matrix.m01 == '0) && (matrix.m22 == $signed(ONE)))
    else $error("zero quaternion did not give identity");
endmodule
`default_nettype wire

/* verif/quaternion_to_rotation_matrix_tb.sv */
// Testbench for the quaternion to rotation matrix converter: directed table plus random quaternions.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_rotation_matrix_tb;

  // Width of the exact arithmetic: products need 32 bits, the shifted forms
  // a few more, and the divider shifts the remainder left once per bit.
  localparam int WIDE = 72;
  localparam int OW   = q2rm_pkg::OUT_W;
  localparam int OF   = q2rm_pkg::OUT_FRAC;
  localparam logic signed [OW-1:0] ONE = OW'(1) << OF;

  typedef struct {
    q2rm_pkg::quat_t   q;
    bit                has_exp;
    q2rm_pkg::matrix_t m;
  } row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  q2rm_pkg::quat_t   quat;
  logic              done;
  q2rm_pkg::matrix_t matrix;

  q2rm_pkg::matrix_t expected_matrices[$];
  int                mismatch_count;
  int                send_idle_pct;
  bit                any_fail;

  quaternion_to_rotation_matrix uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat(quat), .done(done), .matrix(matrix)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One entry: the exact quotient e / n, rounded half away from zero and
  // clamped to plus or minus one.
  function automatic logic signed [OW-1:0] ratio_q14(logic signed [WIDE-1:0] e,
                                                    logic signed [WIDE-1:0] n);
    logic signed [WIDE-1:0] a;
    logic [OW-1:0] q;
    logic [OW-1:0] mag;
    bit neg;
    neg = e < 0;
    a = neg ? -e : e;
    q = '0;
    if (a >= n) begin
      mag = ONE;
    end else begin
      for (int i = 0; i < OF + 1; i++) begin
        a = a <<< 1;
        q = q << 1;
        if (a >= n) begin
          a = a - n;
          q[0] = 1'b1;
        end
      end
      mag = (q + 1'b1) >> 1;
      if (mag > ONE) mag = ONE;
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // Rotation matrix of the normalized quaternion, each entry E/N.
  function automatic q2rm_pkg::matrix_t rotation_of(q2rm_pkg::quat_t q);
    logic signed [WIDE-1:0] x, y, z, w, n;
    q2rm_pkg::matrix_t r;
    x = q.qx; y = q.qy; z = q.qz; w = q.qw;
    n = x*x + y*y + z*z + w*w;
    if (n == 0) begin
      r = '0;
      r.m00 = ONE; r.m11 = ONE; r.m22 = ONE;
      return r;
    end
    r.m00 = ratio_q14(n - 2*(y*y + z*z), n);
    r.m01 = ratio_q14(2*(x*y + z*w), n);
    r.m02 = ratio_q14(2*(x*z - y*w), n);
    r.m10 = ratio_q14(2*(x*y - z*w), n);
    r.m11 = ratio_q14(n - 2*(x*x + z*z), n);
    r.m12 = ratio_q14(2*(y*z + x*w), n);
    r.m20 = ratio_q14(2*(x*z + y*w), n);
    r.m21 = ratio_q14(2*(y*z - x*w), n);
    r.m22 = ratio_q14(n - 2*(x*x + y*y), n);
    return r;
  endfunction

  function automatic logic signed [q2rm_pkg::IN_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
      2: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  // Checker: the receiver cannot stall, so every cycle with done high is a
  // completed result transfer and is matched against the oldest expectation.
  always @(posedge clk) begin
    q2rm_pkg::matrix_t exp_m;
    if (!rst && done) begin
      if (expected_matrices.size() == 0) begin
        any_fail = 1'b1;
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", matrix);
      end else begin
        exp_m = expected_matrices.pop_front();
        if (exp_m !== matrix) begin
          any_fail = 1'b1;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("matrix mismatch: expected %h got %h", exp_m, matrix);
        end
      end
    end
  end

  // Drive one quaternion at the falling edge and hold it until a transfer
  // happens at a rising edge. start stays high between back to back items.
  task automatic send_quat(q2rm_pkg::quat_t q, bit has_exp, q2rm_pkg::matrix_t given);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    quat  = q;
    do @(posedge clk); while (busy);
    expected_matrices.push_back(has_exp ? given : rotation_of(q));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain();
    while (expected_matrices.size() != 0) @(negedge clk);
  endtask

  initial begin
    row_t              table_rows[$];
    row_t              r;
    q2rm_pkg::matrix_t ident;
    q2rm_pkg::quat_t   q;
    rst = 1'b1;
    start = 1'b0;
    quat = '0;
    mismatch_count = 0;
    send_idle_pct = 0;
    any_fail = 1'b0;
    ident = '0;
    ident.m00 = ONE; ident.m11 = ONE; ident.m22 = ONE;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows. Zero quaternion and pure w give the identity; a pure
    // axis rotation by pi gives plus one on that axis and minus one elsewhere.
    r.has_exp = 1; r.m = ident;
    r.q = '{0, 0, 0, 0};                    table_rows.push_back(r);
    r.q = '{0, 0, 0, 16'sh7fff};            table_rows.push_back(r);
    r.q = '{0, 0, 0, 16'sh8000};            table_rows.push_back(r);
    r.q = '{0, 0, 0, 1};                    table_rows.push_back(r);
    r.m = '0; r.m.m00 = ONE; r.m.m11 = -ONE; r.m.m22 = -ONE;
    r.q = '{16'sh8000, 0, 0, 0};            table_rows.push_back(r);
    r.m = '0; r.m.m00 = -ONE; r.m.m11 = ONE; r.m.m22 = -ONE;
    r.q = '{0, 16'sh7fff, 0, 0};            table_rows.push_back(r);
    r.m = '0; r.m.m00 = -ONE; r.m.m11 = -ONE; r.m.m22 = ONE;
    r.q = '{0, 0, -1, 0};                   table_rows.push_back(r);
    r.has_exp = 0;
    r.q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}; table_rows.push_back(r);
    r.q = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}; table_rows.push_back(r);
    r.q = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}; table_rows.push_back(r);
    r.q = '{1, 1, 1, 1};                    table_rows.push_back(r);
    r.q = '{-1, 2, -3, 4};                  table_rows.push_back(r);
    r.q = '{16'sh1000, 0, 0, 16'sh1000};    table_rows.push_back(r);
    r.q = '{16'sh5555, 16'shaaaa, 3, 16'shffff}; table_rows.push_back(r);
    r.q = '{1, 0, 0, 16'sh7fff};            table_rows.push_back(r);
    foreach (table_rows[i]) send_quat(table_rows[i].q, table_rows[i].has_exp, table_rows[i].m);
    // Hold off until the pipeline is empty before the random part.
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 66 : (ph == 2 ? 34 : 0);
      for (int k = 0; k < 125; k++) begin
        q.qx = rand_comp(); q.qy = rand_comp();
        q.qz = rand_comp(); q.qw = rand_comp();
        send_quat(q, 0, ident);
      end
    end

    drain();
    repeat (q2rm_pkg::LATENCY + 5) @(negedge clk);
    if (!any_fail && expected_matrices.size() == 0) begin
      $display("** quaternion_to_rotation_matrix: PASSED **");
    end else begin
      $display("** quaternion_to_rotation_matrix: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** quaternion_to_rotation_matrix: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
rtl/q2rm_pkg.sv
rtl/quaternion_to_rotation_matrix.sv
verif/quaternion_to_rotation_matrix_tb.sv
